/* sv/ctem_pkg.sv */
`timescale 1ns / 1ps
// ctem_pkg: shared constants, status codes and transaction types of the
// corner table edge matcher. No dependencies.
package ctem_pkg;

  localparam int unsigned VERTEX_BITS   = 16;
  localparam int unsigned MAX_TRIANGLES = 4096;
  localparam int unsigned EDGE_SLOTS    = 16384;

  localparam logic [31:0] HASH_MUL_FROM = 32'd2654435761;
  localparam logic [31:0] HASH_MUL_TO   = 32'd40503;
  localparam int unsigned HASH_SHIFT    = 13;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DEGEN  = 2'd1;
  localparam logic [1:0] ST_EXISTS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [15:0] vertex_a;
    logic [15:0] vertex_b;
    logic [15:0] vertex_c;
    logic        new_mesh;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] triangle_index;
    logic        pair_valid;
    logic [13:0] corner_new;
    logic [13:0] corner_old;
    logic        last;
  } result_t;

endpackage

/* sv/ctem_ram.sv */
`timescale 1ns / 1ps
// ctem_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module ctem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ctem_hash.sv */
`timescale 1ns / 1ps
// ctem_hash: multi-cycle edge hash with one shared 32x32 multiplier, used for the
// mix products and for a reciprocal remainder. Depends on ctem_pkg.
module ctem_hash #(
  parameter int unsigned EDGE_SLOTS = ctem_pkg::EDGE_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [31:0]                   from_i,
  input  logic [31:0]                   to_i,
  output logic                          done_o,
  output logic [$clog2(EDGE_SLOTS)-1:0] slot_o
);

  localparam int unsigned SW = $clog2(EDGE_SLOTS);
  localparam bit IS_POW2 = ((1 << SW) == EDGE_SLOTS);
  localparam logic [31:0] SLOTS_32 = 32'(EDGE_SLOTS);
  // floor(2^(31+SW) / EDGE_SLOTS): quotient estimate is low by at most one
  localparam logic [31:0] RECIP = 32'((64'd1 << (31 + SW)) / 64'(EDGE_SLOTS));

  typedef enum logic [2:0] {H_IDLE, H_M1, H_M2, H_MIX, H_RQ, H_RP, H_RC} hstate_e;

  hstate_e state_q, state_d;
  logic [31:0] p1_q, p1_d, p2_q, p2_d, h_q, h_d, q_q, q_d, r_q, r_d;
  logic [SW-1:0] slot_q, slot_d;
  logic done_q, done_d;
  logic [31:0] mul_a, mul_b, mix;
  logic [63:0] mul_p;

  always_comb begin
    case (state_q)
      H_M1: begin
        mul_a = from_i;
        mul_b = ctem_pkg::HASH_MUL_FROM;
      end
      H_M2: begin
        mul_a = to_i;
        mul_b = ctem_pkg::HASH_MUL_TO;
      end
      H_RQ: begin
        mul_a = h_q;
        mul_b = RECIP;
      end
      H_RP: begin
        mul_a = q_q;
        mul_b = SLOTS_32;
      end
      default: begin
        mul_a = from_i;
        mul_b = ctem_pkg::HASH_MUL_FROM;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign mix = p1_q ^ (p2_q + (p1_q >> ctem_pkg::HASH_SHIFT));

  always_comb begin
    state_d = state_q;
    p1_d = p1_q;
    p2_d = p2_q;
    h_d = h_q;
    q_d = q_q;
    r_d = r_q;
    slot_d = slot_q;
    done_d = 1'b0;
    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          state_d = H_M1;
        end
      end
      H_M1: begin
        p1_d = mul_p[31:0];
        state_d = H_M2;
      end
      H_M2: begin
        p2_d = mul_p[31:0];
        state_d = H_MIX;
      end
      H_MIX: begin
        h_d = mix;
        if (IS_POW2) begin
          slot_d = mix[SW-1:0];
          done_d = 1'b1;
          state_d = H_IDLE;
        end else begin
          state_d = H_RQ;
        end
      end
      H_RQ: begin
        q_d = 32'(mul_p >> (31 + SW));
        state_d = H_RP;
      end
      H_RP: begin
        r_d = h_q - mul_p[31:0];
        state_d = H_RC;
      end
      H_RC: begin
        slot_d = (r_q >= SLOTS_32) ? SW'(r_q - SLOTS_32) : SW'(r_q);
        done_d = 1'b1;
        state_d = H_IDLE;
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
    p2_q <= p2_d;
    h_q <= h_d;
    q_q <= q_d;
    r_q <= r_d;
    slot_q <= slot_d;
  end

  assign done_o = done_q;
  assign slot_o = slot_q;

endmodule

/* sv/corner_table_edge_matcher.sv */
`timescale 1ns / 1ps
// corner_table_edge_matcher: top level, sequencer over a hashed edge store
// with linear probing. Depends on ctem_pkg, ctem_hash and ctem_ram.
//
//  channel   | direction | handshake             | payload
//  item      | in        | start_i & !busy_o     | item_i   (ctem_pkg::item_t)
//  result    | out       | result_valid_o strobe | result_o (ctem_pkg::result_t)
//
// One triangle: a check in S_CHECK, up to six hashes (with extra remainder steps
// when EDGE_SLOTS is not a power of two), S_RD then S_CMP per probed slot over up
// to nine probe runs (inserts reuse the forward hash), then S_OUT gives one to three
// results; rejections stop early. Reset and each new_mesh run a clearing pass over
// all EDGE_SLOTS slots of the store memory; busy_o is high during it.
// Results are strobed for one cycle each, with possible gaps; the receiver cannot stall.
module corner_table_edge_matcher #(
  parameter int unsigned VERTEX_BITS   = ctem_pkg::VERTEX_BITS,
  parameter int unsigned MAX_TRIANGLES = ctem_pkg::MAX_TRIANGLES,
  parameter int unsigned EDGE_SLOTS    = ctem_pkg::EDGE_SLOTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ctem_pkg::item_t   item_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output ctem_pkg::result_t result_o
);

  localparam int unsigned VB = VERTEX_BITS;
  localparam int unsigned SW = $clog2(EDGE_SLOTS);
  localparam int unsigned PW = SW + 1;
  localparam int unsigned TW = $clog2(MAX_TRIANGLES + 1);
  localparam int unsigned CW = $clog2(3 * MAX_TRIANGLES);
  localparam int unsigned UW = $clog2(EDGE_SLOTS + 1);
  localparam int unsigned EW = 1 + 2 * VB + CW;
  localparam logic [SW-1:0] SLOT_LAST = SW'(EDGE_SLOTS - 1);
  localparam logic [PW-1:0] PROBE_LAST = PW'(EDGE_SLOTS - 1);
  localparam logic [UW:0] SLOTS_U = (UW+1)'(EDGE_SLOTS);
  localparam logic [TW-1:0] TRI_MAX = TW'(MAX_TRIANGLES);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_CHECK, S_HASH, S_HWAIT, S_RD, S_CMP, S_OUT
  } state_e;

  typedef enum logic [1:0] {M_FIND, M_REV, M_INS} mode_e;

  state_e state_q, state_d;
  mode_e mode_q, mode_d;
  logic [VB-1:0] v_q [3];
  logic [VB-1:0] v_d [3];
  logic [SW-1:0] hfw_q [3];
  logic [SW-1:0] hfw_d [3];
  logic [CW-1:0] old_q [3];
  logic [CW-1:0] old_d [3];
  logic [2:0] hit_q, hit_d;
  logic [1:0] e_q, e_d, e1, k_q, k_d;
  logic [SW-1:0] slot_q, slot_d, slot_nx;
  logic [PW-1:0] probe_q, probe_d;
  logic [TW-1:0] tcnt_q, tcnt_d, tri_q, tri_d;
  logic [UW-1:0] used_q, used_d;
  logic [1:0] status_q, status_d;
  logic pend_q, pend_d;
  logic res_valid_q, res_valid_d;
  ctem_pkg::result_t res_q, res_d;

  logic hash_start, hash_done;
  logic [SW-1:0] hash_slot;
  logic [31:0] hash_from, hash_to;
  logic [VB-1:0] key_from, key_to;
  logic ram_we;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic r_valid, r_match;
  logic [VB-1:0] r_from, r_to;
  logic [CW-1:0] r_corner, c3, corner_e, corner_k;
  logic later_hit;

  assign e1 = (e_q == 2'd2) ? 2'd0 : e_q + 2'd1;
  assign key_from = (mode_q == M_REV) ? v_q[e1] : v_q[e_q];
  assign key_to = (mode_q == M_REV) ? v_q[e_q] : v_q[e1];
  assign hash_from = 32'(key_from);
  assign hash_to = 32'(key_to);
  assign hash_start = (state_q == S_HASH);

  assign r_valid = ram_rdata[EW-1];
  assign r_from = ram_rdata[EW-2 -: VB];
  assign r_to = ram_rdata[EW-2-VB -: VB];
  assign r_corner = ram_rdata[CW-1:0];
  assign r_match = r_valid && (r_from == key_from) && (r_to == key_to);

  assign slot_nx = (slot_q == SLOT_LAST) ? '0 : slot_q + SW'(1);
  assign c3 = (CW'(tri_q) << 1) + CW'(tri_q);
  assign corner_e = (e_q == 2'd0) ? c3 + CW'(2) : (e_q == 2'd1) ? c3 : c3 + CW'(1);
  assign corner_k = (k_q == 2'd0) ? c3 + CW'(2) : (k_q == 2'd1) ? c3 : c3 + CW'(1);
  assign later_hit = (k_q == 2'd0) ? (hit_q[1] | hit_q[2]) :
                     (k_q == 2'd1) ? hit_q[2] : 1'b0;

  ctem_hash #(
    .EDGE_SLOTS(EDGE_SLOTS)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hash_start),
    .from_i (hash_from),
    .to_i   (hash_to),
    .done_o (hash_done),
    .slot_o (hash_slot)
  );

  ctem_ram #(
    .WIDTH(EW),
    .DEPTH(EDGE_SLOTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(ram_wdata),
    .raddr_i(slot_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    v_d = v_q;
    hfw_d = hfw_q;
    old_d = old_q;
    hit_d = hit_q;
    e_d = e_q;
    k_d = k_q;
    slot_d = slot_q;
    probe_d = probe_q;
    tcnt_d = tcnt_q;
    tri_d = tri_q;
    used_d = used_q;
    status_d = status_q;
    pend_d = pend_q;
    res_valid_d = 1'b0;
    res_d = res_q;
    ram_we = 1'b0;
    ram_wdata = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          v_d[0] = VB'(item_i.vertex_a);
          v_d[1] = VB'(item_i.vertex_b);
          v_d[2] = VB'(item_i.vertex_c);
          if (item_i.new_mesh) begin
            slot_d = '0;
            tcnt_d = '0;
            used_d = '0;
            pend_d = 1'b1;
            state_d = S_CLEAR;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CLEAR: begin
        ram_we = 1'b1;
        slot_d = slot_nx;
        if (slot_q == SLOT_LAST) begin
          pend_d = 1'b0;
          state_d = pend_q ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        tri_d = tcnt_q;
        k_d = '0;
        hit_d = '0;
        if (tcnt_q >= TRI_MAX) begin
          status_d = ctem_pkg::ST_FULL;
          state_d = S_OUT;
        end else begin
          tcnt_d = tcnt_q + TW'(1);
          if (v_q[0] == v_q[1] || v_q[1] == v_q[2] || v_q[0] == v_q[2]) begin
            status_d = ctem_pkg::ST_DEGEN;
            state_d = S_OUT;
          end else begin
            mode_d = M_FIND;
            e_d = '0;
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        state_d = S_HWAIT;
      end
      S_HWAIT: begin
        if (hash_done) begin
          slot_d = hash_slot;
          probe_d = '0;
          if (mode_q == M_FIND) begin
            hfw_d[e_q] = hash_slot;
          end
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (mode_q == M_INS) begin
          if (!r_valid) begin
            ram_we = 1'b1;
            ram_wdata = {1'b1, key_from, key_to, corner_e};
            used_d = used_q + UW'(1);
            if (e_q == 2'd2) begin
              status_d = ctem_pkg::ST_OK;
              state_d = S_OUT;
            end else begin
              e_d = e_q + 2'd1;
              mode_d = M_REV;
              state_d = S_HASH;
            end
          end else begin
            slot_d = slot_nx;
            state_d = S_RD;
          end
        end else if (r_match || !r_valid || probe_q == PROBE_LAST) begin
          if (mode_q == M_FIND) begin
            if (r_match) begin
              status_d = ctem_pkg::ST_EXISTS;
              state_d = S_OUT;
            end else if (e_q != 2'd2) begin
              e_d = e_q + 2'd1;
              state_d = S_HASH;
            end else if ((UW+1)'(used_q) + (UW+1)'(3) > SLOTS_U) begin
              status_d = ctem_pkg::ST_FULL;
              state_d = S_OUT;
            end else begin
              e_d = '0;
              mode_d = M_REV;
              state_d = S_HASH;
            end
          end else begin
            hit_d[e_q] = r_match;
            old_d[e_q] = r_corner;
            mode_d = M_INS;
            slot_d = hfw_q[e_q];
            state_d = S_RD;
          end
        end else begin
          slot_d = slot_nx;
          probe_d = probe_q + PW'(1);
          state_d = S_RD;
        end
      end
      S_OUT: begin
        res_d.status = status_q;
        res_d.triangle_index = 12'(tri_q);
        if (status_q != ctem_pkg::ST_OK || hit_q == 3'b000) begin
          res_d.pair_valid = 1'b0;
          res_d.corner_new = '0;
          res_d.corner_old = '0;
          res_d.last = 1'b1;
          res_valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          res_d.pair_valid = 1'b1;
          res_d.corner_new = 14'(corner_k);
          res_d.corner_old = 14'(old_q[k_q]);
          res_d.last = !later_hit;
          res_valid_d = hit_q[k_q];
          k_d = k_q + 2'd1;
          if (hit_q[k_q] && !later_hit) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      mode_q <= M_FIND;
      slot_q <= '0;
      pend_q <= 1'b0;
      tcnt_q <= '0;
      used_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      slot_q <= slot_d;
      pend_q <= pend_d;
      tcnt_q <= tcnt_d;
      used_q <= used_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    hfw_q <= hfw_d;
    old_q <= old_d;
    hit_q <= hit_d;
    e_q <= e_d;
    k_q <= k_d;
    probe_q <= probe_d;
    tri_q <= tri_d;
    status_q <= status_d;
    res_q <= res_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o = res_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after accepted transaction");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (UW+1)'(used_q) <= SLOTS_U)
    else $error("edge store count exceeds capacity");

  a_pair_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.pair_valid |-> result_o.status == ctem_pkg::ST_OK)
    else $error("pair result with reject status");

  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != ctem_pkg::ST_OK |-> result_o.last)
    else $error("rejected triangle gave more than one result");

endmodule

/* dv/tb_corner_table_edge_matcher.sv */
`timescale 1ns / 1ps
// tb_corner_table_edge_matcher: self-checking testbench for the corner table
// edge matcher. Depends on ctem_pkg and corner_table_edge_matcher.
module tb_corner_table_edge_matcher;

  localparam int unsigned WATCHDOG_CYCLES = 200000;

  typedef struct packed {
    logic        chk;
    logic [1:0]  status;
    logic [11:0] tri_idx;
  } row_exp_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  ctem_pkg::item_t   item_i;
  logic              busy_o;
  logic              result_valid_o;
  ctem_pkg::result_t result_o;

  corner_table_edge_matcher u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // mirror of the edge store
  logic        mir_valid  [ctem_pkg::EDGE_SLOTS];
  logic [15:0] mir_from   [ctem_pkg::EDGE_SLOTS];
  logic [15:0] mir_to     [ctem_pkg::EDGE_SLOTS];
  logic [13:0] mir_corner [ctem_pkg::EDGE_SLOTS];
  int unsigned tri_count;
  int unsigned edges_used;

  ctem_pkg::result_t pending_results[$];
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_pairs;
  int unsigned n_reject;
  logic [15:0] vpool[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned hash_slot(logic [15:0] f, logic [15:0] t);
    logic [31:0] h;
    h = 32'(f) * ctem_pkg::HASH_MUL_FROM;
    h = h ^ ((32'(t) * ctem_pkg::HASH_MUL_TO) + (h >> ctem_pkg::HASH_SHIFT));
    return h % ctem_pkg::EDGE_SLOTS;
  endfunction

  function automatic int unsigned find_edge(logic [15:0] f, logic [15:0] t);
    int unsigned s;
    s = hash_slot(f, t);
    for (int unsigned n = 0; n < ctem_pkg::EDGE_SLOTS; n++) begin
      if (!mir_valid[s]) return ctem_pkg::EDGE_SLOTS;
      if (mir_from[s] == f && mir_to[s] == t) return s;
      s = (s + 1) % ctem_pkg::EDGE_SLOTS;
    end
    return ctem_pkg::EDGE_SLOTS;
  endfunction

  function automatic void store_edge(logic [15:0] f, logic [15:0] t, logic [13:0] c);
    int unsigned s;
    s = hash_slot(f, t);
    for (int unsigned n = 0; n < ctem_pkg::EDGE_SLOTS; n++) begin
      if (!mir_valid[s]) begin
        mir_valid[s] = 1'b1;
        mir_from[s] = f;
        mir_to[s] = t;
        mir_corner[s] = c;
        edges_used++;
        return;
      end
      s = (s + 1) % ctem_pkg::EDGE_SLOTS;
    end
  endfunction

  function automatic void clear_mesh();
    for (int i = 0; i < ctem_pkg::EDGE_SLOTS; i++) mir_valid[i] = 1'b0;
    tri_count = 0;
    edges_used = 0;
  endfunction

  function automatic void push_single(logic [1:0] st, int unsigned t);
    ctem_pkg::result_t r;
    r = '0;
    r.status = st;
    r.triangle_index = t[11:0];
    r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void match_triangle(ctem_pkg::item_t it);
    logic [15:0] v[3];
    logic [13:0] cor[3];
    int unsigned t, s, first;
    logic [1:0] st;
    ctem_pkg::result_t r;
    if (it.new_mesh) clear_mesh();
    v[0] = it.vertex_a;
    v[1] = it.vertex_b;
    v[2] = it.vertex_c;
    t = tri_count;
    if (t >= ctem_pkg::MAX_TRIANGLES) begin
      push_single(ctem_pkg::ST_FULL, t);
      return;
    end
    tri_count = t + 1;
    st = ctem_pkg::ST_OK;
    if (v[0] == v[1] || v[1] == v[2] || v[0] == v[2]) st = ctem_pkg::ST_DEGEN;
    else if (find_edge(v[0], v[1]) != ctem_pkg::EDGE_SLOTS ||
             find_edge(v[1], v[2]) != ctem_pkg::EDGE_SLOTS ||
             find_edge(v[2], v[0]) != ctem_pkg::EDGE_SLOTS) st = ctem_pkg::ST_EXISTS;
    else if (edges_used + 3 > ctem_pkg::EDGE_SLOTS) st = ctem_pkg::ST_FULL;
    if (st != ctem_pkg::ST_OK) begin
      push_single(st, t);
      return;
    end
    cor[0] = 14'(3 * t + 2);
    cor[1] = 14'(3 * t);
    cor[2] = 14'(3 * t + 1);
    first = pending_results.size();
    for (int i = 0; i < 3; i++) begin
      s = find_edge(v[(i + 1) % 3], v[i]);
      if (s != ctem_pkg::EDGE_SLOTS) begin
        r = '0;
        r.status = ctem_pkg::ST_OK;
        r.triangle_index = t[11:0];
        r.pair_valid = 1'b1;
        r.corner_new = cor[i];
        r.corner_old = mir_corner[s];
        pending_results.push_back(r);
      end
      store_edge(v[i], v[(i + 1) % 3], cor[i]);
    end
    if (pending_results.size() == first) push_single(ctem_pkg::ST_OK, t);
    else pending_results[$].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      ctem_pkg::result_t want;
      n_results++;
      if (result_o.pair_valid) n_pairs++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, result_o);
      end else begin
        want = pending_results.pop_front();
        if (result_o !== want) begin
          errors++;
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, result_o);
        end
      end
    end
    if (!rst_ni || result_valid_o || (start_i && !busy_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic idle_gap();
    int unsigned g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) start_i <= 1'b0;
    repeat (g) @(posedge clk_i);
  endtask

  task automatic send_triangle(ctem_pkg::item_t it, logic [1:0] want_st, bit chk);
    int unsigned first;
    start_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    first = pending_results.size();
    match_triangle(it);
    if (chk && pending_results[first].status !== want_st) begin
      errors++;
      $display("%0t: directed row, expected status %0d, actual predicted %0d", $time,
               want_st, pending_results[first].status);
    end
    if (it.vertex_a != it.vertex_b) vpool.push_back(it.vertex_a);
    if (vpool.size() > 24) void'(vpool.pop_front());
    n_items++;
    if (pending_results[$].status != ctem_pkg::ST_OK) n_reject++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_vertex();
    if (vpool.size() != 0 && $urandom_range(0, 2) != 0)
      return vpool[$urandom_range(0, vpool.size() - 1)];
    return 16'($urandom_range(0, 47));
  endfunction

  typedef struct {
    ctem_pkg::item_t it;
    row_exp_t        ex;
  } stim_row_t;

  stim_row_t dir_rows[$];

  function automatic stim_row_t mk(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                   logic nm, logic chk, logic [1:0] st);
    stim_row_t r;
    r.it = '{vertex_a: a, vertex_b: b, vertex_c: c, new_mesh: nm};
    r.ex = '{chk: chk, status: st, tri_idx: '0};
    return r;
  endfunction

  initial begin
    ctem_pkg::item_t it;
    logic [15:0] a, b, c;
    int unsigned k;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    errors = 0;
    idle_cycles = 0;
    n_items = 0;
    n_results = 0;
    n_pairs = 0;
    n_reject = 0;
    clear_mesh();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    dir_rows.push_back(mk(16'd0, 16'd1, 16'd2, 1'b0, 1'b1, ctem_pkg::ST_OK));
    dir_rows.push_back(mk(16'd2, 16'd1, 16'd3, 1'b0, 1'b1, ctem_pkg::ST_OK));
    dir_rows.push_back(mk(16'd0, 16'd1, 16'd9, 1'b0, 1'b1, ctem_pkg::ST_EXISTS));
    dir_rows.push_back(mk(16'd5, 16'd5, 16'd6, 1'b0, 1'b1, ctem_pkg::ST_DEGEN));
    dir_rows.push_back(mk(16'd5, 16'd6, 16'd6, 1'b0, 1'b1, ctem_pkg::ST_DEGEN));
    dir_rows.push_back(mk(16'd7, 16'd6, 16'd7, 1'b0, 1'b1, ctem_pkg::ST_DEGEN));
    dir_rows.push_back(mk(16'hFFFF, 16'h0000, 16'hAAAA, 1'b0, 1'b1, ctem_pkg::ST_OK));
    dir_rows.push_back(mk(16'h0000, 16'hFFFF, 16'h5555, 1'b0, 1'b1, ctem_pkg::ST_OK));
    dir_rows.push_back(mk(16'h5555, 16'hFFFF, 16'hAAAA, 1'b0, 1'b0, ctem_pkg::ST_OK));
    dir_rows.push_back(mk(16'h2, 16'h0, 16'h3, 1'b0, 1'b0, ctem_pkg::ST_OK));
    dir_rows.push_back(mk(16'd0, 16'd1, 16'd2, 1'b1, 1'b1, ctem_pkg::ST_OK));
    dir_rows.push_back(mk(16'd1, 16'd0, 16'd2, 1'b0, 1'b0, ctem_pkg::ST_OK));
    dir_rows.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, ctem_pkg::ST_DEGEN));
    foreach (dir_rows[i]) begin
      idle_gap();
      send_triangle(dir_rows[i].it, dir_rows[i].ex.status, dir_rows[i].ex.chk);
    end
    drain();

    for (int n = 0; n < 417; n++) begin
      k = $urandom_range(0, 99);
      if (n % 150 == 149) drain();
      if (k < 70) begin
        a = pick_vertex();
        b = pick_vertex();
        c = pick_vertex();
        // pick two earlier vertices so that a stored edge may recur reversed, creating matches
        if ($urandom_range(0, 1) && vpool.size() > 1) begin
          b = vpool[$];
          a = vpool[$urandom_range(0, vpool.size() - 1)];
        end
        it = '{vertex_a: a, vertex_b: b, vertex_c: c, new_mesh: 1'b0};
      end else if (k < 97) begin
        it = '{vertex_a: 16'($urandom), vertex_b: 16'($urandom), vertex_c: 16'($urandom),
               new_mesh: 1'b0};
      end else begin
        it = '{vertex_a: 16'($urandom), vertex_b: 16'($urandom), vertex_c: 16'($urandom),
               new_mesh: 1'b1};
      end
      idle_gap();
      send_triangle(it, ctem_pkg::ST_OK, 1'b0);
    end

    drain();
    repeat (300) @(posedge clk_i);
    $display("Covered %0d triangles (%0d rejected), %0d results with %0d corner pairs.",
             n_items, n_reject, n_results, n_pairs);
    $display("Directed rows, reversed edge matches and mesh clears included.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
